// ===== rtl/core/sslc_pkg.sv =====
// Shared types and constants of the soft-switch and language-card controller.
`default_nettype none

package sslc_pkg;

    typedef enum logic [1:0] {
        OP_PAGE_READ   = 2'd0,
        OP_SWITCH_SET  = 2'd1,
        OP_KEY_ARRIVAL = 2'd2,
        OP_EXP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        DEV_NONE     = 3'd0,
        DEV_SPEAKER  = 3'd1,
        DEV_CASSETTE = 3'd2,
        DEV_BUTTON   = 3'd3,
        DEV_ANALOG   = 3'd4,
        DEV_PADDLE   = 3'd5,
        DEV_PRINTER  = 3'd6,
        DEV_FLOPPY   = 3'd7
    } dev_t;

    // High nibble of the page address.
    localparam logic [3:0] PG_KEYBOARD = 4'h0;
    localparam logic [3:0] PG_STATUS   = 4'h1;
    localparam logic [3:0] PG_CASSETTE = 4'h2;
    localparam logic [3:0] PG_SPEAKER  = 4'h3;
    localparam logic [3:0] PG_DISPLAY  = 4'h5;
    localparam logic [3:0] PG_GAME_IO  = 4'h6;
    localparam logic [3:0] PG_PADDLE   = 4'h7;
    localparam logic [3:0] PG_BANK     = 4'h8;
    localparam logic [3:0] PG_PRINTER  = 4'h9;
    localparam logic [3:0] PG_FLOPPY   = 4'hE;

    // Low nibble within the status group.
    localparam logic [3:0] ST_KEY_CLEAR  = 4'h0;
    localparam logic [3:0] ST_BANK2      = 4'h1;
    localparam logic [3:0] ST_READ_RAM   = 4'h2;
    localparam logic [3:0] ST_MODE_FIRST = 4'h3;
    localparam logic [3:0] ST_MODE_LAST  = 4'h8;
    localparam logic [3:0] ST_TEXT       = 4'hA;
    localparam logic [3:0] ST_MIXED      = 4'hB;
    localparam logic [3:0] ST_PAGE2      = 4'hC;
    localparam logic [3:0] ST_HIRES      = 4'hD;
    localparam logic [3:0] ST_ALTCHAR    = 4'hE;
    localparam logic [3:0] ST_COL80      = 4'hF;

    // Low nibble within the display, game and paddle groups.
    localparam logic [3:0] DSP_DHIRES_ON  = 4'hE;
    localparam logic [3:0] DSP_DHIRES_OFF = 4'hF;
    localparam logic [3:0] GIO_ANALOG     = 4'h4;
    localparam logic [3:0] GIO_STATE      = 4'h8;
    localparam logic [3:0] PAD_RESET      = 4'h0;

    // Bit positions in the memory mode byte.
    localparam int unsigned MM_AUXREAD  = 0;
    localparam int unsigned MM_AUXWRITE = 1;
    localparam int unsigned MM_CXROM    = 2;
    localparam int unsigned MM_ALTZP    = 3;
    localparam int unsigned MM_ALTCHAR  = 6;
    localparam int unsigned MM_COL80    = 7;

    localparam logic [7:0] STAT_ON = 8'h80;

    typedef struct packed {
        op_t        operation;
        logic [7:0] address_low;
        logic [2:0] switch_index;
        logic       switch_value;
        logic [6:0] key_code;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        dev_t       device_request;
        logic [3:0] device_register;
        logic       high_read_ram;
        logic       high_bank2;
        logic       high_write_enable;
        logic       alt_zero_page_out;
        logic       internal_rom_out;
        logic [2:0] active_slot;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/sslc_if.sv =====
// Request and result channel interfaces of the soft-switch controller.
`default_nettype none

interface sslc_req_if;
    logic          valid;
    logic          ready;
    sslc_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sslc_rsp_if;
    logic          valid;
    logic          ready;
    sslc_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/soft_switch_language_card_ctrl.sv =====
// Soft-switch page decoder with language-card bank switching of high RAM.
//
// Usage: every request on the req channel (page read, write-side switch set,
// key arrival or expansion release) produces exactly one result on the rsp
// channel. Both channels use valid/ready; a request is taken at a clock edge
// where both are high. The result carries the byte read, a forwarded device
// request code and the memory map state after the request.
// The request is captured in an input register, then the decode and switch
// update run into the result register. Throughput is one request per cycle
// while rsp does not stall; the decode of one registered request
// is the only work between the two registers.
// While rsp stalls, one further request is still taken into the input
// register; after that req.ready falls until the result is taken.
// Reset clears every switch, the keyboard latch, the bank-switch logic and
// both pipeline stages; no request is taken while rst_n is low.
`default_nettype none

module soft_switch_language_card_ctrl (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sslc_req_if.sink   req,
    sslc_rsp_if.source rsp
);

    logic           s1_valid_reg;
    sslc_pkg::req_t s1_req_reg;
    logic           rsp_valid_reg;
    sslc_pkg::rsp_t rsp_data_reg;
    logic           advance;

    logic [7:0] kbd_reg, kbd_next;
    logic       text_reg, text_next;
    logic       mixed_reg, mixed_next;
    logic       page2_reg, page2_next;
    logic       hires_reg, hires_next;
    logic       dhires_reg, dhires_next;
    logic       bank2_reg, bank2_next;
    logic       rdram_reg, rdram_next;
    logic       preset_reg, preset_next;
    logic       wen_reg, wen_next;
    logic [7:0] mm_reg, mm_next;
    logic [2:0] slot_reg, slot_next;

    sslc_pkg::rsp_t rsp_next;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = rst_n && (!s1_valid_reg || advance);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            if (req.ready) begin
                s1_valid_reg <= req.valid;
            end
            if (advance) begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.valid && req.ready) begin
            s1_req_reg <= req.data;
        end
        if (advance) begin
            rsp_data_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kbd_reg    <= '0;
            text_reg   <= 1'b0;
            mixed_reg  <= 1'b0;
            page2_reg  <= 1'b0;
            hires_reg  <= 1'b0;
            dhires_reg <= 1'b0;
            bank2_reg  <= 1'b0;
            rdram_reg  <= 1'b0;
            preset_reg <= 1'b0;
            wen_reg    <= 1'b0;
            mm_reg     <= '0;
            slot_reg   <= '0;
        end
        else if (advance) begin
            kbd_reg    <= kbd_next;
            text_reg   <= text_next;
            mixed_reg  <= mixed_next;
            page2_reg  <= page2_next;
            hires_reg  <= hires_next;
            dhires_reg <= dhires_next;
            bank2_reg  <= bank2_next;
            rdram_reg  <= rdram_next;
            preset_reg <= preset_next;
            wen_reg    <= wen_next;
            mm_reg     <= mm_next;
            slot_reg   <= slot_next;
        end
    end

    always_comb begin
        logic [3:0]     hi;
        logic [3:0]     lo;
        logic [7:0]     data;
        sslc_pkg::dev_t dev;
        logic [2:0]     mode_sel;

        hi       = s1_req_reg.address_low[7:4];
        lo       = s1_req_reg.address_low[3:0];
        data     = '0;
        dev      = sslc_pkg::DEV_NONE;
        mode_sel = 3'(lo - sslc_pkg::ST_MODE_FIRST);

        kbd_next    = kbd_reg;
        text_next   = text_reg;
        mixed_next  = mixed_reg;
        page2_next  = page2_reg;
        hires_next  = hires_reg;
        dhires_next = dhires_reg;
        bank2_next  = bank2_reg;
        rdram_next  = rdram_reg;
        preset_next = preset_reg;
        wen_next    = wen_reg;
        mm_next     = mm_reg;
        slot_next   = slot_reg;

        case (s1_req_reg.operation)
            sslc_pkg::OP_PAGE_READ:
            begin
                case (hi)
                    sslc_pkg::PG_KEYBOARD:
                    begin
                        data = kbd_reg;
                    end
                    sslc_pkg::PG_STATUS:
                    begin
                        if (lo == sslc_pkg::ST_KEY_CLEAR) begin
                            kbd_next = {1'b0, kbd_reg[6:0]};
                        end
                        else if (lo == sslc_pkg::ST_BANK2) begin
                            data = bank2_reg ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo == sslc_pkg::ST_READ_RAM) begin
                            data = rdram_reg ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo >= sslc_pkg::ST_MODE_FIRST
                                 && lo <= sslc_pkg::ST_MODE_LAST) begin
                            data = mm_reg[mode_sel] ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo == sslc_pkg::ST_TEXT) begin
                            data = text_reg ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo == sslc_pkg::ST_MIXED) begin
                            data = mixed_reg ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo == sslc_pkg::ST_PAGE2) begin
                            data = page2_reg ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo == sslc_pkg::ST_HIRES) begin
                            data = hires_reg ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo == sslc_pkg::ST_ALTCHAR) begin
                            data = mm_reg[sslc_pkg::MM_ALTCHAR] ? sslc_pkg::STAT_ON : '0;
                        end
                        else if (lo == sslc_pkg::ST_COL80) begin
                            data = mm_reg[sslc_pkg::MM_COL80] ? sslc_pkg::STAT_ON : '0;
                        end
                    end
                    sslc_pkg::PG_CASSETTE:
                    begin
                        dev = sslc_pkg::DEV_CASSETTE;
                    end
                    sslc_pkg::PG_SPEAKER:
                    begin
                        dev = sslc_pkg::DEV_SPEAKER;
                    end
                    sslc_pkg::PG_DISPLAY:
                    begin
                        // Lower eight addresses clear or set the four display
                        // flags in pairs; bit 0 is the new value.
                        if (!lo[3]) begin
                            case (lo[2:1])
                                2'd0:    text_next  = lo[0];
                                2'd1:    mixed_next = lo[0];
                                2'd2:    page2_next = lo[0];
                                default: hires_next = lo[0];
                            endcase
                        end
                        else if (lo == sslc_pkg::DSP_DHIRES_ON) begin
                            dhires_next = 1'b1;
                        end
                        else if (lo == sslc_pkg::DSP_DHIRES_OFF) begin
                            dhires_next = 1'b0;
                        end
                    end
                    sslc_pkg::PG_GAME_IO:
                    begin
                        if (lo < sslc_pkg::GIO_ANALOG) begin
                            dev = sslc_pkg::DEV_BUTTON;
                        end
                        else if (lo < sslc_pkg::GIO_STATE) begin
                            dev = sslc_pkg::DEV_ANALOG;
                        end
                        else if (lo == sslc_pkg::GIO_STATE) begin
                            data = {mm_reg[sslc_pkg::MM_ALTZP], page2_reg,
                                    mm_reg[sslc_pkg::MM_AUXREAD],
                                    mm_reg[sslc_pkg::MM_AUXWRITE], 1'b0,
                                    bank2_reg, 1'b0, mm_reg[sslc_pkg::MM_CXROM]};
                        end
                    end
                    sslc_pkg::PG_PADDLE:
                    begin
                        if (lo == sslc_pkg::PAD_RESET) begin
                            dev = sslc_pkg::DEV_PADDLE;
                        end
                    end
                    sslc_pkg::PG_BANK:
                    begin
                        // Two odd accesses in a row enable writes; an even
                        // access disarms the sequence and write-protects.
                        bank2_next = !lo[3];
                        rdram_next = !(lo[1] ^ lo[0]);
                        if (lo[0]) begin
                            preset_next = 1'b1;
                            wen_next    = wen_reg | preset_reg;
                        end
                        else begin
                            preset_next = 1'b0;
                            wen_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        // Slot groups 9 through F select slots 1 through 7.
                        if (hi[3]) begin
                            slot_next = hi[2:0];
                            if (hi == sslc_pkg::PG_PRINTER) begin
                                dev = sslc_pkg::DEV_PRINTER;
                            end
                            else if (hi == sslc_pkg::PG_FLOPPY) begin
                                dev = sslc_pkg::DEV_FLOPPY;
                            end
                        end
                    end
                endcase
            end
            sslc_pkg::OP_SWITCH_SET:
            begin
                mm_next[s1_req_reg.switch_index] = s1_req_reg.switch_value;
            end
            sslc_pkg::OP_KEY_ARRIVAL:
            begin
                kbd_next = {1'b1, s1_req_reg.key_code};
            end
            default:
            begin
                mm_next[sslc_pkg::MM_CXROM] = 1'b0;
                slot_next = '0;
            end
        endcase

        rsp_next.read_data         = data;
        rsp_next.device_request    = dev;
        rsp_next.device_register   = (dev != sslc_pkg::DEV_NONE) ? lo : '0;
        rsp_next.high_read_ram     = rdram_next;
        rsp_next.high_bank2        = bank2_next;
        rsp_next.high_write_enable = wen_next;
        rsp_next.alt_zero_page_out = mm_next[sslc_pkg::MM_ALTZP];
        rsp_next.internal_rom_out  = mm_next[sslc_pkg::MM_CXROM];
        rsp_next.active_slot       = slot_next;
    end

    a_dev_reg_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.device_request == sslc_pkg::DEV_NONE
            |-> rsp_data_reg.device_register == 4'h0)
        else $error("device register set without a device request");

    a_write_enable_after_preset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wen_reg) |-> $past(preset_reg))
        else $error("high RAM write enable rose without an armed preset");

    a_key_sets_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_req_reg.operation == sslc_pkg::OP_KEY_ARRIVAL |=> kbd_reg[7])
        else $error("key arrival did not set the keyboard strobe");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg && rsp_data_reg.high_write_enable == wen_reg)
        else $error("decoded request did not reach the result register");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the soft-switch page decoder with language-card bank switching.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned REQUEST_TARGET = 1300;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned HOLD_AFTER     = 300;
    localparam int unsigned HOLD_CYCLES    = 200;

    typedef enum int unsigned {
        RX_STEADY,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_e;

    // Tracks the switch state and predicts the result of each request.
    class switch_page_scoreboard;
        logic [7:0] key_latch;
        logic       text_on, mixed_on, page2_on, hires_on, dhires_on;
        logic       bank2_on, read_ram_on, write_armed, write_on;
        logic [7:0] mode_bits;
        logic [2:0] slot;
        sslc_pkg::rsp_t expected_results[$];
        int unsigned error_count;

        function new();
            key_latch   = '0;
            text_on     = 1'b0;
            mixed_on    = 1'b0;
            page2_on    = 1'b0;
            hires_on    = 1'b0;
            dhires_on   = 1'b0;
            bank2_on    = 1'b0;
            read_ram_on = 1'b0;
            write_armed = 1'b0;
            write_on    = 1'b0;
            mode_bits   = '0;
            slot        = '0;
            error_count = 0;
        endfunction

        function logic [7:0] status_byte(logic flag);
            return flag ? sslc_pkg::STAT_ON : 8'h00;
        endfunction

        function sslc_pkg::rsp_t decode_access(sslc_pkg::req_t r);
            sslc_pkg::rsp_t res;
            logic [3:0]     hi;
            logic [3:0]     lo;
            res = '0;
            hi  = r.address_low[7:4];
            lo  = r.address_low[3:0];
            case (r.operation)
                sslc_pkg::OP_PAGE_READ:
                begin
                    case (hi)
                        sslc_pkg::PG_KEYBOARD: res.read_data = key_latch;
                        sslc_pkg::PG_STATUS:
                        begin
                            case (lo)
                                sslc_pkg::ST_KEY_CLEAR: key_latch[7] = 1'b0;
                                sslc_pkg::ST_BANK2:
                                    res.read_data = status_byte(bank2_on);
                                sslc_pkg::ST_READ_RAM:
                                    res.read_data = status_byte(read_ram_on);
                                sslc_pkg::ST_TEXT:
                                    res.read_data = status_byte(text_on);
                                sslc_pkg::ST_MIXED:
                                    res.read_data = status_byte(mixed_on);
                                sslc_pkg::ST_PAGE2:
                                    res.read_data = status_byte(page2_on);
                                sslc_pkg::ST_HIRES:
                                    res.read_data = status_byte(hires_on);
                                sslc_pkg::ST_ALTCHAR:
                                    res.read_data =
                                        status_byte(mode_bits[sslc_pkg::MM_ALTCHAR]);
                                sslc_pkg::ST_COL80:
                                    res.read_data =
                                        status_byte(mode_bits[sslc_pkg::MM_COL80]);
                                default:
                                begin
                                    // The vertical blank slot falls through and reads 0.
                                    if (lo >= sslc_pkg::ST_MODE_FIRST
                                        && lo <= sslc_pkg::ST_MODE_LAST)
                                        res.read_data = status_byte(
                                            mode_bits[lo - sslc_pkg::ST_MODE_FIRST]);
                                end
                            endcase
                        end
                        sslc_pkg::PG_CASSETTE: res.device_request = sslc_pkg::DEV_CASSETTE;
                        sslc_pkg::PG_SPEAKER:  res.device_request = sslc_pkg::DEV_SPEAKER;
                        sslc_pkg::PG_DISPLAY:
                        begin
                            // The low eight addresses come in clear/set pairs:
                            // text, mixed, page 2, hires.
                            if (lo < 4'h8)
                            begin
                                case (lo[2:1])
                                    2'd0:    text_on  = lo[0];
                                    2'd1:    mixed_on = lo[0];
                                    2'd2:    page2_on = lo[0];
                                    default: hires_on = lo[0];
                                endcase
                            end
                            else if (lo == sslc_pkg::DSP_DHIRES_ON)
                                dhires_on = 1'b1;
                            else if (lo == sslc_pkg::DSP_DHIRES_OFF)
                                dhires_on = 1'b0;
                        end
                        sslc_pkg::PG_GAME_IO:
                        begin
                            if (lo < sslc_pkg::GIO_ANALOG)
                                res.device_request = sslc_pkg::DEV_BUTTON;
                            else if (lo < sslc_pkg::GIO_STATE)
                                res.device_request = sslc_pkg::DEV_ANALOG;
                            else if (lo == sslc_pkg::GIO_STATE)
                                res.read_data = {mode_bits[sslc_pkg::MM_ALTZP], page2_on,
                                                 mode_bits[sslc_pkg::MM_AUXREAD],
                                                 mode_bits[sslc_pkg::MM_AUXWRITE],
                                                 1'b0, bank2_on, 1'b0,
                                                 mode_bits[sslc_pkg::MM_CXROM]};
                        end
                        sslc_pkg::PG_PADDLE:
                        begin
                            if (lo == sslc_pkg::PAD_RESET)
                                res.device_request = sslc_pkg::DEV_PADDLE;
                        end
                        sslc_pkg::PG_BANK:
                        begin
                            bank2_on    = !lo[3];
                            read_ram_on = (lo[1] == lo[0]);
                            // Two odd accesses in a row open high RAM for writing.
                            if (lo[0])
                            begin
                                if (write_armed)
                                    write_on = 1'b1;
                                write_armed = 1'b1;
                            end
                            else
                            begin
                                write_armed = 1'b0;
                                write_on    = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (hi >= sslc_pkg::PG_PRINTER)
                            begin
                                slot = hi[2:0];
                                if (hi == sslc_pkg::PG_PRINTER)
                                    res.device_request = sslc_pkg::DEV_PRINTER;
                                else if (hi == sslc_pkg::PG_FLOPPY)
                                    res.device_request = sslc_pkg::DEV_FLOPPY;
                            end
                        end
                    endcase
                end
                sslc_pkg::OP_SWITCH_SET:  mode_bits[r.switch_index] = r.switch_value;
                sslc_pkg::OP_KEY_ARRIVAL: key_latch = {1'b1, r.key_code};
                default:
                begin
                    mode_bits[sslc_pkg::MM_CXROM] = 1'b0;
                    slot = 3'd0;
                end
            endcase
            res.device_register   = (res.device_request != sslc_pkg::DEV_NONE) ? lo : 4'h0;
            res.high_read_ram     = read_ram_on;
            res.high_bank2        = bank2_on;
            res.high_write_enable = write_on;
            res.alt_zero_page_out = mode_bits[sslc_pkg::MM_ALTZP];
            res.internal_rom_out  = mode_bits[sslc_pkg::MM_CXROM];
            res.active_slot       = slot;
            return res;
        endfunction

        function void note_request(sslc_pkg::req_t r);
            expected_results.push_back(decode_access(r));
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(sslc_pkg::rsp_t got);
            sslc_pkg::rsp_t want;
            if (expected_results.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", got);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("device_request", want.device_request, got.device_request);
            compare_field("device_register", want.device_register, got.device_register);
            compare_field("high_read_ram", want.high_read_ram, got.high_read_ram);
            compare_field("high_bank2", want.high_bank2, got.high_bank2);
            compare_field("high_write_enable", want.high_write_enable,
                          got.high_write_enable);
            compare_field("alt_zero_page_out", want.alt_zero_page_out,
                          got.alt_zero_page_out);
            compare_field("internal_rom_out", want.internal_rom_out, got.internal_rom_out);
            compare_field("active_slot", want.active_slot, got.active_slot);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int unsigned cycle_count = 0;

    sslc_req_if req_bus ();
    sslc_rsp_if rsp_bus ();

    switch_page_scoreboard board = new();

    soft_switch_language_card_ctrl i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Requests are noted before results are checked, so a request and its own
    // result never meet at one edge out of order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
                board.note_request(req_bus.data);
            if (rsp_bus.valid && rsp_bus.ready)
                board.check_result(rsp_bus.data);
        end
    end

    // Result side: changing stall patterns, plus one long hold-off that
    // lets the pipeline fill and push back on the request side.
    initial
    begin
        int unsigned results_taken;
        int unsigned hold_left;
        int unsigned mode_left;
        logic        hold_done;
        rx_mode_e    rx_mode;
        results_taken = 0;
        hold_left     = 0;
        mode_left     = 0;
        hold_done     = 1'b0;
        rx_mode       = RX_STEADY;
        rsp_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
                results_taken++;
            if (!hold_done && results_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_e'($urandom_range(RX_STEADY, RX_SPARSE));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_STEADY: rsp_bus.ready <= 1'b1;
                    RX_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
                    default:   rsp_bus.ready <= (mode_left % 4 == 0);
                endcase
            end
        end
    end

    function automatic sslc_pkg::req_t noise_request();
        logic [31:0]                       wide;
        logic [$bits(sslc_pkg::req_t)-1:0] raw;
        wide = $urandom;
        raw  = wide[$bits(sslc_pkg::req_t)-1:0];
        return sslc_pkg::req_t'(raw);
    endfunction

    function automatic sslc_pkg::req_t page_access(logic [7:0] addr);
        sslc_pkg::req_t r;
        r             = noise_request();
        r.operation   = sslc_pkg::OP_PAGE_READ;
        r.address_low = addr;
        return r;
    endfunction

    function automatic sslc_pkg::req_t switch_write(logic [2:0] index, logic value);
        sslc_pkg::req_t r;
        r              = noise_request();
        r.operation    = sslc_pkg::OP_SWITCH_SET;
        r.switch_index = index;
        r.switch_value = value;
        return r;
    endfunction

    function automatic sslc_pkg::req_t key_press(logic [6:0] code);
        sslc_pkg::req_t r;
        r           = noise_request();
        r.operation = sslc_pkg::OP_KEY_ARRIVAL;
        r.key_code  = code;
        return r;
    endfunction

    function automatic sslc_pkg::req_t expansion_release();
        sslc_pkg::req_t r;
        r           = noise_request();
        r.operation = sslc_pkg::OP_EXP_RELEASE;
        return r;
    endfunction

    function automatic sslc_pkg::req_t random_request();
        sslc_pkg::req_t r;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            r = page_access(8'($urandom));
            // Steer half of the reads into the groups that hold state.
            case ($urandom_range(0, 5))
                0:       r.address_low[7:4] = sslc_pkg::PG_BANK;
                1:       r.address_low[7:4] = sslc_pkg::PG_STATUS;
                2:       r.address_low[7:4] = sslc_pkg::PG_DISPLAY;
                default: ;
            endcase
        end
        else if (pick < 80)
            r = switch_write(3'($urandom), 1'($urandom));
        else if (pick < 93)
            r = key_press(7'($urandom));
        else
            r = expansion_release();
        return r;
    endfunction

    // Leaves valid high after acceptance so back-to-back requests need no gap.
    task automatic send_request(input sslc_pkg::req_t r);
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    task automatic pause_requests(input int unsigned cycles);
        if (cycles > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    initial
    begin
        sslc_pkg::req_t directed[$];
        int unsigned    sent;
        int unsigned    burst;
        int unsigned    k;
        rst_n         = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(key_press(7'h7F));
        directed.push_back(page_access(8'h00));
        directed.push_back(page_access(8'h10));
        directed.push_back(page_access(8'h00));
        directed.push_back(key_press(7'h00));
        directed.push_back(switch_write(3'(sslc_pkg::MM_COL80), 1'b1));
        directed.push_back(switch_write(3'(sslc_pkg::MM_ALTZP), 1'b1));
        directed.push_back(switch_write(3'(sslc_pkg::MM_CXROM), 1'b1));
        directed.push_back(switch_write(3'(sslc_pkg::MM_AUXREAD), 1'b1));
        directed.push_back(page_access(8'h55));
        directed.push_back(page_access(8'h68));
        directed.push_back(page_access(8'h1F));
        directed.push_back(page_access(8'h19));
        directed.push_back(page_access(8'h81));
        directed.push_back(page_access(8'h8D));
        directed.push_back(page_access(8'h8B));
        directed.push_back(page_access(8'h86));
        directed.push_back(page_access(8'h90));
        directed.push_back(page_access(8'hEF));
        directed.push_back(expansion_release());
        directed.push_back(page_access(8'hFF));
        directed.push_back(page_access(8'h5E));
        directed.push_back(page_access(8'h20));
        directed.push_back(page_access(8'h37));
        directed.push_back(page_access(8'h63));
        directed.push_back(page_access(8'h70));
        directed.push_back(page_access(8'h4F));
        foreach (directed[i])
            send_request(directed[i]);
        pause_requests(3);

        sent = 0;
        while (sent < REQUEST_TARGET)
        begin
            burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
            for (k = 0; k < burst; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    // Two odd bank accesses in a row, the sequence that
                    // opens high RAM for writing.
                    send_request(page_access({sslc_pkg::PG_BANK, 3'($urandom), 1'b1}));
                    send_request(page_access({sslc_pkg::PG_BANK, 3'($urandom), 1'b1}));
                    sent += 2;
                end
                else
                begin
                    send_request(random_request());
                    sent++;
                end
            end
            pause_requests($urandom_range(0, 6));
        end
        req_bus.valid <= 1'b0;

        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
